### src/bcbp_pkg.sv
// Types and constants shared by the bit stream packer modules.
package bcbp_pkg;

    localparam int BYTE_BITS = 8;
    localparam int PEND_BITS = 7;
    localparam int CNT_W     = 4;
    localparam int TOT_OUT_W = 32;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int Q_CW      = 3;

    localparam logic [PEND_BITS-1:0] PEND_MASK = 7'h7f;
    localparam logic [CNT_W-1:0]     FULL_CNT  = 4'd8;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] valid_bits;
        logic             final_item;
    } t_in;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic [CNT_W-1:0]     out_valid_bits;
        logic                 is_last;
        logic [TOT_OUT_W-1:0] total_bits;
    } t_result;

    // Zero, one or two results written into the queue in one cycle.
    typedef struct packed {
        logic    has_a;
        logic    has_b;
        t_result res_a;
        t_result res_b;
    } t_push;

endpackage

### src/bcbp_front.sv
// Front end: merges an accepted byte with the pending bits and forms its results.
module bcbp_front import bcbp_pkg::*; #(
    parameter int TOTAL_WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_in   i_item,
    output t_push o_push
);

    localparam int TW1 = TOTAL_WIDTH + 1;

    logic [PEND_BITS-1:0]   r_pend, n_pend;
    logic [2:0]             r_cnt, n_cnt;
    logic [TOTAL_WIDTH-1:0] r_total, n_total;

    logic [CNT_W-1:0]       nbits;
    logic [8:0]             mask9;
    logic [7:0]             data_m;
    logic [14:0]            merged;
    logic [CNT_W-1:0]       sum;
    logic [TOTAL_WIDTH:0]   tsum;
    logic [TOTAL_WIDTH-1:0] new_total;
    logic [63:0]            total_wide;
    logic [TOT_OUT_W-1:0]   total_out;
    logic                   full_byte;
    logic [PEND_BITS-1:0]   rem_bits;
    logic [2:0]             rem_cnt;
    logic                   flush;
    t_result                flush_res;

    always_comb begin
        // Counts above eight act as eight.
        nbits      = i_item.valid_bits[3] ? FULL_CNT : i_item.valid_bits;
        mask9      = (9'd1 << nbits) - 9'd1;
        data_m     = i_item.data_byte & mask9[7:0];
        merged     = {8'b0, r_pend} | (15'(data_m) << r_cnt);
        sum        = {1'b0, r_cnt} + nbits;
        tsum       = {1'b0, r_total} + TW1'(nbits);
        new_total  = tsum[TOTAL_WIDTH] ? '1 : tsum[TOTAL_WIDTH-1:0];
        total_wide = 64'(new_total);
        total_out  = total_wide[TOT_OUT_W-1:0];
        full_byte  = sum >= FULL_CNT;

        if (full_byte) begin
            rem_bits = merged[14:8];
            rem_cnt  = sum[2:0];
        end else begin
            rem_bits = merged[6:0] & PEND_MASK;
            rem_cnt  = sum[2:0];
        end

        // Flush a partial byte, or an empty marker when nothing was emitted.
        flush = i_item.final_item && ((rem_cnt != 3'd0) || !full_byte);
        flush_res.out_byte       = {1'b0, rem_bits};
        flush_res.out_valid_bits = {1'b0, rem_cnt};
        flush_res.is_last        = 1'b1;
        flush_res.total_bits     = total_out;

        o_push = '0;
        if (full_byte) begin
            o_push.has_a                = i_accept;
            o_push.res_a.out_byte       = merged[7:0];
            o_push.res_a.out_valid_bits = FULL_CNT;
            o_push.res_a.is_last        = i_item.final_item && !flush;
            o_push.res_a.total_bits     = (i_item.final_item && !flush) ? total_out : '0;
            o_push.has_b                = i_accept && flush;
            o_push.res_b                = flush_res;
        end else begin
            o_push.has_a = i_accept && flush;
            o_push.res_a = flush_res;
        end

        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_total = r_total;
        if (i_accept) begin
            if (i_item.final_item) begin
                n_pend  = '0;
                n_cnt   = '0;
                n_total = '0;
            end else begin
                n_pend  = rem_bits;
                n_cnt   = rem_cnt;
                n_total = new_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_cnt   <= '0;
            r_total <= '0;
        end else begin
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_total <= n_total;
        end
    end

endmodule

### src/bcbp_queue.sv
// Back end: result queue with two write slots and one read port.
module bcbp_queue import bcbp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_head
);

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_CW-1:0] r_count, n_count;
    logic            do_pop;
    logic [Q_AW-1:0] wr_b;

    always_comb begin
        o_empty = r_count == '0;
        // Hold off the front unless two slots are free.
        o_full  = r_count > Q_CW'(Q_DEPTH - 2);
        o_head  = r_mem[r_rd];
        do_pop  = i_pop && !o_empty;
        wr_b    = r_wr + Q_AW'(1);
        n_wr    = r_wr + Q_AW'(i_push.has_a) + Q_AW'(i_push.has_b);
        n_rd    = r_rd + Q_AW'(do_pop);
        n_count = r_count + Q_CW'(i_push.has_a) + Q_CW'(i_push.has_b) - Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.has_a) begin
            r_mem[r_wr] <= i_push.res_a;
        end
        if (i_push.has_b) begin
            r_mem[wr_b] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### src/bitmap_concat_bit_packer_core.sv
// Top level of the LSB-first bit stream packer.
//
//   channel   | handshake         | word
//   ----------+-------------------+---------------------------------------------
//   input     | push / full       | i_item: data_byte, valid_bits, final_item
//   result    | empty / pop       | o_result: out_byte, out_valid_bits,
//             |                   |           is_last, total_bits
//
// One input word is taken each cycle while full is low; its zero to two results
// go into a four-entry queue and leave one per cycle while pop is high.
// full rises when fewer than two queue slots are free, so the input rate
// is set by the single result read port.
// Reset clears the pending bits, the running total and the queue.
// A stalled pop backs up the queue and then stalls push; nothing is dropped.
module bitmap_concat_bit_packer_core import bcbp_pkg::*; #(
    parameter int TOTAL_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_in     i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic  accept;
    t_push push_req;

    assign accept = push && !full;

    bcbp_front #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push_req)
    );

    bcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_req),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (o_result)
    );

endmodule

### src/bcbp_checker.sv
// Port-level checks for the bit stream packer, bound to the top level.
module bcbp_checker import bcbp_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input t_in     i_item,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // A partial word only appears as the closing flush.
    a_partial_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_valid_bits != FULL_CNT) |-> o_result.is_last)
        else $error("partial word not marked last");

    // Words before the end carry eight bits and no total.
    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.is_last) |->
        (o_result.total_bits == '0 && o_result.out_valid_bits == FULL_CNT))
        else $error("non-final word carries a total or partial count");

    // An empty marker word must carry a cleared out_byte.
    a_zero_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_valid_bits == '0) |-> o_result.out_byte == '0)
        else $error("empty marker word has data bits");

    // A final input word always leaves at least one result behind.
    a_final_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_item.final_item) |=> !empty)
        else $error("final input produced no result");

endmodule

bind bitmap_concat_bit_packer_core bcbp_checker u_bcbp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_item   (i_item),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

### bench/tb_bitmap_concat_bit_packer_core.sv
// Self-checking testbench for the LSB-first bit stream packer core.
module tb_bitmap_concat_bit_packer_core;
    import bcbp_pkg::*;

    // Run with a 16-bit running total, narrower than the 32-bit total_bits field.
    localparam int TOT_W     = 16;
    localparam int RAND_ITEMS = 700;

    typedef struct {
        t_in     item;
        bit      fixed;
        t_result want;
    } t_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_in     i_item;
    logic    empty;
    logic    pop;
    t_result o_result;

    // Packer model state
    logic [6:0]  pend_bits_m;
    logic [2:0]  pend_cnt_m;
    logic [63:0] run_total_m;

    t_result exp_words[$];
    t_row    dir_rows[$];
    int      errors;
    int      words_popped;
    int      items_sent;
    bit      burst;
    bit      held;

    bitmap_concat_bit_packer_core #(.TOTAL_WIDTH(TOT_W)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("** bitmap_concat_bit_packer_core: FAILED **");
        $finish;
    end

    // Advance the packer model by one input word; return the results it makes.
    function automatic int pack_step(input t_in it, output t_result ra, output t_result rb);
        logic [3:0]  n;
        logic [8:0]  mask;
        logic [7:0]  data;
        logic [15:0] merged;
        logic [4:0]  sum;
        logic [63:0] tmax;
        logic        last_here;
        int          cnt;
        t_result     r;
        cnt  = 0;
        ra   = '0;
        rb   = '0;
        n    = (it.valid_bits > 4'd8) ? 4'd8 : it.valid_bits;
        mask = (9'd1 << n) - 9'd1;
        data = it.data_byte & mask[7:0];
        merged = {9'd0, pend_bits_m} | ({8'd0, data} << pend_cnt_m);
        sum  = {2'd0, pend_cnt_m} + {1'b0, n};
        tmax = (64'd1 << TOT_W) - 64'd1;
        if (run_total_m > tmax - n) begin
            run_total_m = tmax;
        end else begin
            run_total_m = run_total_m + n;
        end
        if (sum >= 5'd8) begin
            last_here = it.final_item && (sum == 5'd8);
            r.out_byte       = merged[7:0];
            r.out_valid_bits = FULL_CNT;
            r.is_last        = last_here;
            r.total_bits     = last_here ? run_total_m[31:0] : 32'd0;
            ra  = r;
            cnt = 1;
            merged = merged >> 8;
            sum    = sum - 5'd8;
        end
        pend_bits_m = merged[6:0];
        pend_cnt_m  = sum[2:0];
        if (it.final_item) begin
            if (pend_cnt_m != 3'd0 || cnt == 0) begin
                // flush the partial byte, or report an empty final
                r.out_byte       = {1'b0, pend_bits_m};
                r.out_valid_bits = {1'b0, pend_cnt_m};
                r.is_last        = 1'b1;
                r.total_bits     = run_total_m[31:0];
                if (cnt == 0) ra = r;
                else rb = r;
                cnt++;
            end
            pend_bits_m = '0;
            pend_cnt_m  = '0;
            run_total_m = '0;
        end
        return cnt;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t word %0d: %s got %0h want %0h",
                 $realtime, words_popped, what, got, want);
        errors++;
    endtask

    task automatic add_row(input logic [7:0] d, input logic [3:0] vb, input logic fin,
                           input bit fixed, input logic [7:0] wb, input logic [3:0] wvb,
                           input logic wl, input logic [31:0] wt);
        t_row row;
        row.item  = '{data_byte: d, valid_bits: vb, final_item: fin};
        row.fixed = fixed;
        row.want  = '{out_byte: wb, out_valid_bits: wvb, is_last: wl, total_bits: wt};
        dir_rows.push_back(row);
    endtask

    // Offer one word after a gap; hold it until taken, then queue its results.
    task automatic send(input t_in it, input int gap, input bit fixed, input t_result want);
        t_result ra;
        t_result rb;
        int      cnt;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        cnt = pack_step(it, ra, rb);
        items_sent++;
        if (fixed) begin
            exp_words.push_back(want);
        end else begin
            if (cnt > 0) exp_words.push_back(ra);
            if (cnt > 1) exp_words.push_back(rb);
        end
    endtask

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic t_in rand_word(input logic [3:0] vb, input logic fin);
        t_in w;
        w.data_byte  = 8'($urandom_range(0, 255));
        w.valid_bits = vb;
        w.final_item = fin;
        return w;
    endfunction

    // Result side: pop with random stalls, one long hold-off, and check each word.
    initial begin
        t_result want;
        int      gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            @(negedge i_clk);
            if (!held && words_popped == 40) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (150) @(negedge i_clk);
            end else if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (exp_words.size() == 0) begin
                report("unexpected word, byte", o_result.out_byte, 0);
            end else begin
                want = exp_words.pop_front();
                if (o_result.out_byte !== want.out_byte)
                    report("out_byte", o_result.out_byte, want.out_byte);
                if (o_result.out_valid_bits !== want.out_valid_bits)
                    report("out_valid_bits", o_result.out_valid_bits, want.out_valid_bits);
                if (o_result.is_last !== want.is_last)
                    report("is_last", o_result.is_last, want.is_last);
                if (o_result.total_bits !== want.total_bits)
                    report("total_bits", o_result.total_bits, want.total_bits);
            end
            words_popped++;
        end
    end

    initial begin
        t_in     w;
        t_result none;
        int      nmaps;
        int      nbytes;
        errors       = 0;
        words_popped = 0;
        items_sent   = 0;
        burst        = 1'b0;
        held         = 1'b0;
        none         = '0;
        pend_bits_m  = '0;
        pend_cnt_m   = '0;
        run_total_m  = '0;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_item       = '0;

        //       data   vb     fin   fixed  byte   vb     last  total
        add_row(8'hFF, 4'd8,  1'b1, 1'b1, 8'hFF, 4'd8, 1'b1, 32'd8);
        add_row(8'h00, 4'd0,  1'b1, 1'b1, 8'h00, 4'd0, 1'b1, 32'd0);
        add_row(8'hFF, 4'd1,  1'b1, 1'b1, 8'h01, 4'd1, 1'b1, 32'd1);
        add_row(8'hAA, 4'd15, 1'b1, 1'b1, 8'hAA, 4'd8, 1'b1, 32'd8);
        add_row(8'h5A, 4'd9,  1'b0, 1'b1, 8'h5A, 4'd8, 1'b0, 32'd0);
        add_row(8'hFF, 4'd3,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h00, 4'd8,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hFF, 4'd7,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hC3, 4'd0,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h81, 4'd6,  1'b1, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h7F, 4'd7,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hFF, 4'd8,  1'b1, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h01, 4'd1,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h80, 4'd8,  1'b1, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h00, 4'd4,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hF0, 4'd4,  1'b1, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h35, 4'd5,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hFF, 4'd0,  1'b1, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hFF, 4'd12, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h0F, 4'd13, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h3C, 4'd2,  1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hE7, 4'd14, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'h96, 4'd10, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);
        add_row(8'hF7, 4'd11, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0, 32'd0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send(dir_rows[k].item, draw_gap(), dir_rows[k].fixed, dir_rows[k].want);

        // Mostly well-formed concatenations, with some noise words mixed in.
        while (items_sent < RAND_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0);
            nmaps = $urandom_range(1, 4);
            for (int m = 0; m < nmaps; m++) begin
                nbytes = $urandom_range(1, 5);
                for (int b = 0; b < nbytes; b++) begin
                    if ($urandom_range(0, 9) == 0)
                        w = rand_word(4'($urandom_range(0, 15)), 1'b0);
                    else if (b == nbytes - 1)
                        w = rand_word(4'($urandom_range(1, 8)),
                                      1'(m == nmaps - 1 && b == nbytes - 1));
                    else
                        w = rand_word(4'd8, 1'b0);
                    send(w, draw_gap(), 1'b0, none);
                end
            end
            if ($urandom_range(0, 7) == 0)
                send(rand_word(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                     draw_gap(), 1'b0, none);
        end

        // Close a byte exactly on the final word, then flush a lone partial word.
        burst = 1'b1;
        send(rand_word(4'd5, 1'b0), 0, 1'b0, none);
        send(rand_word(4'd3, 1'b1), 0, 1'b0, none);
        send(rand_word(4'd7, 1'b1), 0, 1'b0, none);
        burst = 1'b0;

        @(negedge i_clk);
        push <= 1'b0;
        wait (exp_words.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("** bitmap_concat_bit_packer_core: PASSED **");
        end else begin
            $display("** bitmap_concat_bit_packer_core: FAILED **");
        end
        $finish;
    end

endmodule
